### rtl/tsp_pkg.sv
// Shared constants and handshake types for the minimum tour cost block.
// Used by tsp_ctrl, tsp_datapath and tsp_min_tour_cost; depends on nothing.
package tsp_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_CITIES_DEF = 12;
	localparam int COST_BITS_DEF  = 16;

	// Fixed port widths.
	localparam int CITY_W = 4;
	localparam int EDGE_W = 16;
	localparam int CFG_W  = 4;
	localparam int OUT_W  = 20;

	// Configuration register reset value and the smallest usable city count.
	localparam logic [CFG_W-1:0] CITY_COUNT_RESET = 4'd4;
	localparam int MIN_CITIES = 2;

	// Per-step command from the controller to the datapath.
	typedef struct packed {
		logic issue;      // a table step is read this cycle
		logic first;      // first step of a table entry, minimum starts at infinity
		logic last;       // last step of a table entry, entry is written
		logic take;       // this step's candidate takes part in the minimum
		logic tbl_zero;   // empty subset: the table term counts as zero
		logic final_grp;  // the entry being built is the tour result
		logic emit;       // load the finished result into the output register
	} tsp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
	} tsp_sts_t;

endpackage

### rtl/tsp_min_tour_cost.sv
// Top level of the minimum tour cost block: joins the controller and the datapath.
// Depends on tsp_pkg, tsp_ctrl and tsp_datapath.
//
// This block loads a cost matrix one entry per item and, after the item
// flagged last_entry, finds the cheapest closed tour that starts and ends at
// city 0 and visits each of cities 1 to n-1 once, where n is city_count
// clamped to the range 2 to MAX_CITIES. The cost leaves as one result item on
// the output channel. Loading takes one item per cycle while in_stall is low,
// and entries whose row or column is MAX_CITIES or more are dropped. The
// search is a bitmask dynamic program over (subset, city) held in a table
// memory with one read port, and that port sets its length: one candidate is
// read per cycle while an entry is built, each table entry is then written
// while no read is issued, and entries of the empty subset read only the edge
// back home. While the walk runs in_stall is high; loads are taken again as
// soon as the result has been moved to the output register, even if it still
// waits there. city_count may be written at any time through a port that is
// always ready, but takes effect only when the next walk starts. Every entry
// of the active n by n corner of the matrix must be loaded before a walk; an
// entry that was never loaded reads as an unknown value.
module tsp_min_tour_cost #(
	parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF,
	parameter int COST_BITS  = tsp_pkg::COST_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tsp_pkg::CFG_W-1:0]   city_count,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tsp_pkg::CITY_W-1:0]  from_city,
	input  logic [tsp_pkg::CITY_W-1:0]  to_city,
	input  logic [tsp_pkg::EDGE_W-1:0]  edge_cost,
	input  logic                        last_entry,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tsp_pkg::OUT_W-1:0]   min_tour_cost
);

	localparam int SUB_BITS  = MAX_CITIES - 1;
	localparam int CITY_BITS = $clog2(MAX_CITIES);

	tsp_pkg::tsp_cmd_t      cmd;
	tsp_pkg::tsp_sts_t      sts;
	logic [CITY_BITS-1:0]   row;
	logic [CITY_BITS-1:0]   col;
	logic [SUB_BITS-1:0]    rd_subset;
	logic [SUB_BITS-1:0]    wr_subset;
	logic                   in_accept;

	// An item is taken whenever valid is high and the block is not stalling.
	assign in_accept = in_valid && !in_stall;

	tsp_ctrl #(
		.MAX_CITIES (MAX_CITIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.city_count (city_count),
		.in_accept  (in_accept),
		.last_entry (last_entry),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.sts        (sts),
		.row        (row),
		.col        (col),
		.rd_subset  (rd_subset),
		.wr_subset  (wr_subset)
	);

	tsp_datapath #(
		.MAX_CITIES (MAX_CITIES),
		.COST_BITS  (COST_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_accept     (in_accept),
		.from_city     (from_city),
		.to_city       (to_city),
		.edge_cost     (edge_cost),
		.cmd           (cmd),
		.row           (row),
		.col           (col),
		.rd_subset     (rd_subset),
		.wr_subset     (wr_subset),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.min_tour_cost (min_tour_cost)
	);

endmodule

### rtl/tsp_ctrl.sv
// Controller for the minimum tour cost block: city count register, walk
// sequencer over subset, city and next city. Depends on tsp_pkg.
module tsp_ctrl #(
	parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsp_pkg::CFG_W-1:0]         city_count,
	input  logic                              in_accept,
	input  logic                              last_entry,
	output logic                              in_stall,
	output tsp_pkg::tsp_cmd_t                 cmd,
	input  tsp_pkg::tsp_sts_t                 sts,
	output logic [$clog2(MAX_CITIES)-1:0]     row,
	output logic [$clog2(MAX_CITIES)-1:0]     col,
	output logic [MAX_CITIES-2:0]             rd_subset,
	output logic [MAX_CITIES-2:0]             wr_subset
);

	localparam int SUB_BITS  = MAX_CITIES - 1;
	localparam int CITY_BITS = $clog2(MAX_CITIES);
	localparam int CNT_BITS  = $clog2(MAX_CITIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_DONE = 4'b1000
	} tsp_state_t;

	tsp_state_t                 state_q;
	logic [tsp_pkg::CFG_W-1:0]  city_count_q;
	logic [SUB_BITS-1:0]        subset_q;
	logic [SUB_BITS-1:0]        full_q;
	logic [CITY_BITS-1:0]       city_q;
	logic [CITY_BITS-1:0]       next_q;
	logic [CITY_BITS-1:0]       last_city_q;

	logic [CNT_BITS-1:0]        n_clamp;
	logic [SUB_BITS-1:0]        full_mask;
	logic [SUB_BITS-1:0]        bit_mask;
	logic                       subset_zero;
	logic                       group_end;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);

	// Effective city count, clamped to the supported range.
	always_comb begin
		if (int'(city_count_q) < tsp_pkg::MIN_CITIES) begin
			n_clamp = CNT_BITS'(tsp_pkg::MIN_CITIES);
		end else if (int'(city_count_q) > MAX_CITIES) begin
			n_clamp = CNT_BITS'(MAX_CITIES);
		end else begin
			n_clamp = CNT_BITS'(city_count_q);
		end
	end

	assign full_mask   = ~({SUB_BITS{1'b1}} << (n_clamp - CNT_BITS'(1)));
	assign bit_mask    = SUB_BITS'(1) << (next_q - CITY_BITS'(1));
	assign subset_zero = (subset_q == '0);
	assign group_end   = (subset_q == full_q) && (city_q == last_city_q);

	always_comb begin
		cmd.issue     = (state_q == ST_RUN);
		cmd.first     = subset_zero || (next_q == CITY_BITS'(1));
		cmd.last      = subset_zero || (next_q == last_city_q);
		cmd.take      = subset_zero || ((subset_q & bit_mask) != '0);
		cmd.tbl_zero  = subset_zero;
		cmd.final_grp = (subset_q == full_q) && (city_q == '0);
		cmd.emit      = (state_q == ST_DONE) && sts.out_free;
	end

	assign row       = city_q;
	assign col       = next_q;
	assign rd_subset = subset_q & ~bit_mask;
	assign wr_subset = subset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= tsp_pkg::CITY_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			city_count_q <= city_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			subset_q    <= '0;
			full_q      <= '0;
			city_q      <= '0;
			next_q      <= '0;
			last_city_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept && last_entry) begin
						last_city_q <= CITY_BITS'(n_clamp - CNT_BITS'(1));
						full_q      <= full_mask;
						subset_q    <= '0;
						city_q      <= '0;
						next_q      <= '0;
						state_q     <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.last) begin
						state_q <= ST_WAIT;
					end else begin
						next_q <= next_q + CITY_BITS'(1);
					end
				end
				ST_WAIT: begin
					// The entry just finished is written in this state, so the
					// next read waits for that write.
					if (group_end) begin
						state_q <= ST_DONE;
					end else begin
						if (city_q == last_city_q) begin
							city_q   <= '0;
							subset_q <= subset_q + SUB_BITS'(1);
							next_q   <= CITY_BITS'(1);
						end else begin
							city_q <= city_q + CITY_BITS'(1);
							// Entries of the empty subset read column 0, the
							// edge back home.
							next_q <= subset_zero ? '0 : CITY_BITS'(1);
						end
						state_q <= ST_RUN;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_subset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((subset_q & ~full_q) == '0))
		else $error("subset outside the active city set");

	a_city_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (city_q <= last_city_q && next_q <= last_city_q))
		else $error("city counter beyond the active city count");

	a_gap_after_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.last) |=> !cmd.issue)
		else $error("table read issued while an entry is being written");

	a_emit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after a result");

endmodule

### rtl/tsp_datapath.sv
// Datapath for the minimum tour cost block: cost matrix memory, best cost
// table memory, add and compare stage, result and output registers.
// Depends on tsp_pkg.
module tsp_datapath #(
	parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF,
	parameter int COST_BITS  = tsp_pkg::COST_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_accept,
	input  logic [tsp_pkg::CITY_W-1:0]        from_city,
	input  logic [tsp_pkg::CITY_W-1:0]        to_city,
	input  logic [tsp_pkg::EDGE_W-1:0]        edge_cost,
	input  tsp_pkg::tsp_cmd_t                 cmd,
	input  logic [$clog2(MAX_CITIES)-1:0]     row,
	input  logic [$clog2(MAX_CITIES)-1:0]     col,
	input  logic [MAX_CITIES-2:0]             rd_subset,
	input  logic [MAX_CITIES-2:0]             wr_subset,
	output tsp_pkg::tsp_sts_t                 sts,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [tsp_pkg::OUT_W-1:0]         min_tour_cost
);

	localparam int SUB_BITS  = MAX_CITIES - 1;
	localparam int CITY_BITS = $clog2(MAX_CITIES);
	localparam int SUM_BITS  = COST_BITS + $clog2(MAX_CITIES);
	localparam int COST_AW   = 2 * CITY_BITS;
	localparam int TBL_AW    = SUB_BITS + CITY_BITS;

	logic [COST_BITS-1:0] cost_mem [2**COST_AW];
	logic [SUM_BITS-1:0]  tbl_mem  [2**TBL_AW];

	logic [tsp_pkg::EDGE_W+COST_BITS-1:0] edge_wide;
	logic [COST_BITS-1:0]                 edge_val;
	logic                                 in_range;
	logic [COST_AW-1:0]                   load_addr;

	logic [COST_BITS-1:0] cost_rd_s1;
	logic [SUM_BITS-1:0]  tbl_rd_s1;
	logic                 issue_s1;
	logic                 first_s1;
	logic                 last_s1;
	logic                 take_s1;
	logic                 zero_s1;
	logic                 final_s1;
	logic [TBL_AW-1:0]    wr_addr_s1;

	logic [SUM_BITS-1:0]  run_min_q;
	logic [SUM_BITS-1:0]  result_q;
	logic                 out_valid_q;
	logic [tsp_pkg::OUT_W-1:0] min_tour_cost_q;

	logic [SUM_BITS-1:0]  tbl_val;
	logic [SUM_BITS-1:0]  cand;
	logic [SUM_BITS-1:0]  base;
	logic [SUM_BITS-1:0]  new_min;
	logic                 tbl_wr;
	logic [tsp_pkg::OUT_W+SUM_BITS-1:0] out_wide;

	assign edge_wide = {{COST_BITS{1'b0}}, edge_cost};
	assign edge_val  = edge_wide[COST_BITS-1:0];
	assign in_range  = (int'(from_city) < MAX_CITIES) && (int'(to_city) < MAX_CITIES);
	assign load_addr = {from_city[CITY_BITS-1:0], to_city[CITY_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (in_accept && in_range) begin
			cost_mem[load_addr] <= edge_val;
		end
		cost_rd_s1 <= cost_mem[{row, col}];
	end

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			tbl_mem[wr_addr_s1] <= new_min;
		end
		tbl_rd_s1 <= tbl_mem[{rd_subset, col}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		first_s1   <= cmd.first;
		last_s1    <= cmd.last;
		take_s1    <= cmd.take;
		zero_s1    <= cmd.tbl_zero;
		final_s1   <= cmd.final_grp;
		wr_addr_s1 <= {wr_subset, row};
	end

	// One candidate per step: edge cost plus the best cost of the reduced subset.
	assign tbl_val = zero_s1 ? '0 : tbl_rd_s1;
	assign cand    = {{(SUM_BITS-COST_BITS){1'b0}}, cost_rd_s1} + tbl_val;
	assign base    = first_s1 ? '1 : run_min_q;
	assign new_min = (take_s1 && (cand < base)) ? cand : base;
	assign tbl_wr  = issue_s1 && last_s1;

	always_ff @(posedge clk) begin
		if (issue_s1) begin
			run_min_q <= new_min;
		end
		if (tbl_wr && final_s1) begin
			result_q <= new_min;
		end
	end

	assign out_wide     = {{tsp_pkg::OUT_W{1'b0}}, result_q};
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			min_tour_cost_q <= out_wide[tsp_pkg::OUT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign min_tour_cost = min_tour_cost_q;

endmodule
